[sv/ech_pkg.sv]
// shared types and constants for the edge coverage histogram
package ech_pkg;

    localparam int MAP_ENTRIES_DEFAULT = 65536;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] COUNT_MAX = 8'd255;
    localparam logic [15:0] PC_LIMIT_RESET = 16'hFFFF;

    // input command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // work handed from the front end to the map engine
    typedef enum logic [1:0] {
        OP_NONE,
        OP_CLEAR,
        OP_BUMP,
        OP_READ
    } op_t;

    typedef enum logic {
        ST_SWEEP,
        ST_RUN
    } back_state_t;

    // one queue slot handshake: slot present and its operation
    typedef struct packed {
        logic valid;
        op_t  op;
    } qctl_t;

    // map engine status seen by the front end
    typedef struct packed {
        logic sweeping;
    } back_status_t;

endpackage

[sv/ech_front.sv]
// front end: accepts input beats, tracks the run state and classifies each item
module ech_front #(
    parameter int MAP_ENTRIES = ech_pkg::MAP_ENTRIES_DEFAULT,
    parameter int AW = $clog2(MAP_ENTRIES)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_cmd,
    input  logic [63:0]          s_pc_value,
    input  logic [15:0]          s_read_index,
    input  logic [15:0]          pc_limit,
    input  logic                 q_full,
    input  ech_pkg::back_status_t status,
    output ech_pkg::qctl_t       push,
    output logic [AW-1:0]        push_addr
);

    logic [AW:0]   prev_reg, prev_next;
    logic          have_prev_reg, have_prev_next;
    logic [15:0]   samples_reg, samples_next;
    logic          accept;
    logic          rd_in_range;

    assign s_ready = !q_full && !status.sweeping;
    assign accept = s_valid && s_ready;
    assign rd_in_range = (32'(s_read_index) < 32'(MAP_ENTRIES));

    always_comb begin
        prev_next = prev_reg;
        have_prev_next = have_prev_reg;
        samples_next = samples_reg;
        push.valid = accept;
        push.op = ech_pkg::OP_NONE;
        push_addr = '0;
        case (s_cmd)
            ech_pkg::CMD_START: begin
                push.op = ech_pkg::OP_CLEAR;
                if (accept) begin
                    have_prev_next = 1'b0;
                    samples_next = '0;
                end
            end
            ech_pkg::CMD_SAMPLE: begin
                push_addr = prev_reg[AW:1] ^ s_pc_value[AW-1:0];
                if (samples_reg < pc_limit) begin
                    if (have_prev_reg) begin
                        push.op = ech_pkg::OP_BUMP;
                    end
                    if (accept) begin
                        samples_next = samples_reg + 16'd1;
                        prev_next = s_pc_value[AW:0];
                        have_prev_next = 1'b1;
                    end
                end
            end
            ech_pkg::CMD_READ: begin
                push_addr = AW'(s_read_index);
                if (rd_in_range) begin
                    push.op = ech_pkg::OP_READ;
                end
            end
            default: begin
                push.op = ech_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prev_reg <= prev_next;
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            samples_reg <= '0;
        end else begin
            have_prev_reg <= have_prev_next;
            samples_reg <= samples_next;
        end
    end

endmodule

[sv/ech_queue.sv]
// short queue between the front end and the map engine
module ech_queue #(
    parameter int AW = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  ech_pkg::qctl_t push,
    input  logic [AW-1:0]  push_addr,
    output logic           full,
    output ech_pkg::qctl_t head,
    output logic [AW-1:0]  head_addr,
    input  logic           pop
);

    localparam int PW = ech_pkg::QPTR_W;

    ech_pkg::op_t  op_slot [ech_pkg::QUEUE_DEPTH];
    logic [AW-1:0] addr_slot [ech_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          do_push, do_pop;

    assign full = (count_reg == (PW+1)'(ech_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.op = op_slot[rd_ptr_reg];
    assign head_addr = addr_slot[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop = pop && head.valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            op_slot[wr_ptr_reg] <= push.op;
            addr_slot[wr_ptr_reg] <= push_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

[sv/ech_back.sv]
// map engine: counter memory, clearing sweep, read-modify-write and result register
module ech_back #(
    parameter int MAP_ENTRIES = ech_pkg::MAP_ENTRIES_DEFAULT,
    parameter int AW = $clog2(MAP_ENTRIES)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ech_pkg::qctl_t        head,
    input  logic [AW-1:0]         head_addr,
    output logic                  pop,
    output ech_pkg::back_status_t status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [15:0]           m_edge_index,
    output logic [7:0]            m_edge_count,
    output logic                  m_edge_valid
);

    logic [7:0] mem [MAP_ENTRIES];

    ech_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0] sweep_reg, sweep_next;

    // read stage
    logic          s1_valid_reg;
    ech_pkg::op_t  s1_op_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [7:0]    rd_data_reg;
    logic          fwd_hit_reg;
    logic [7:0]    fwd_data_reg;

    // result register
    logic          m_valid_reg;
    logic [15:0]   m_index_reg;
    logic [7:0]    m_count_reg;
    logic          m_edge_valid_reg;

    logic          advance, s1_moves, s1_free;
    logic [7:0]    cur_count, bumped;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    assign advance = !m_valid_reg || m_ready;
    assign s1_moves = s1_valid_reg && advance;
    assign s1_free = !s1_valid_reg || (advance && (s1_op_reg != ech_pkg::OP_CLEAR));
    assign cur_count = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign bumped = (cur_count == ech_pkg::COUNT_MAX) ? ech_pkg::COUNT_MAX
                                                      : cur_count + 8'd1;

    // next state
    always_comb begin
        state_next = state_reg;
        sweep_next = '0;
        case (state_reg)
            ech_pkg::ST_RUN: begin
                if (s1_moves && (s1_op_reg == ech_pkg::OP_CLEAR)) begin
                    state_next = ech_pkg::ST_SWEEP;
                end
            end
            ech_pkg::ST_SWEEP: begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AW'(MAP_ENTRIES - 1)) begin
                    state_next = ech_pkg::ST_RUN;
                end
            end
            default: begin
                state_next = ech_pkg::ST_SWEEP;
            end
        endcase
    end

    // state outputs
    always_comb begin
        status.sweeping = 1'b0;
        pop = 1'b0;
        wr_en = 1'b0;
        wr_addr = s1_addr_reg;
        wr_data = bumped;
        case (state_reg)
            ech_pkg::ST_RUN: begin
                pop = head.valid && s1_free;
                wr_en = s1_moves && (s1_op_reg == ech_pkg::OP_BUMP);
            end
            ech_pkg::ST_SWEEP: begin
                status.sweeping = 1'b1;
                wr_en = 1'b1;
                wr_addr = sweep_reg;
                wr_data = '0;
            end
            default: begin
                status.sweeping = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rd_data_reg <= mem[head_addr];
        end
    end

    // payload of read stage and result register
    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_op_reg <= head.op;
            s1_addr_reg <= head_addr;
            // same edge write is not seen by the read, keep the new value aside
            fwd_data_reg <= bumped;
        end
        if (s1_moves) begin
            m_index_reg <= '0;
            m_count_reg <= '0;
            m_edge_valid_reg <= 1'b0;
            if (s1_op_reg == ech_pkg::OP_BUMP) begin
                m_index_reg <= 16'(s1_addr_reg);
                m_count_reg <= bumped;
                m_edge_valid_reg <= 1'b1;
            end else if (s1_op_reg == ech_pkg::OP_READ) begin
                m_index_reg <= 16'(s1_addr_reg);
                m_count_reg <= cur_count;
                m_edge_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ech_pkg::ST_SWEEP;
            sweep_reg <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            if (pop) begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg <= wr_en && (state_reg == ech_pkg::ST_RUN)
                               && (head_addr == s1_addr_reg);
            end else if (s1_moves) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_moves) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_edge_index = m_index_reg;
    assign m_edge_count = m_count_reg;
    assign m_edge_valid = m_edge_valid_reg;

endmodule

[sv/edge_coverage_histogram.sv]
// top level of the edge coverage histogram: front end, queue, map engine, config register
// Edge-coverage counter map for fuzzing. Each s_ beat carries a command: start (clear the
// map and forget the previous pc), pc sample, or counter read. Consecutive accepted samples
// form an edge index ((previous >> 1) ^ current) mod MAP_ENTRIES whose 8-bit counter is
// bumped, saturating at 255; samples beyond pc_limit in a run are dropped. Every beat in
// gives exactly one m_ beat out (index, count, edge_valid; all zero when no edge or read).
// Throughput is one beat per cycle while m_ready is high and no sweep runs: the map engine
// reads the counter memory into the read stage and writes it back as that stage moves on,
// with a forwarding register covering back-to-back hits on the same entry. The result
// passes through the queue, the read stage and the result register before it is
// presented on m_. After reset and after every start command the map engine sweeps the
// counter memory one entry per cycle while s_ready is held low; cfg writes are accepted
// at any time (cfg_ready is 1).
module edge_coverage_histogram #(
    parameter int MAP_ENTRIES = ech_pkg::MAP_ENTRIES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // item input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [63:0] s_pc_value,
    input  logic [15:0] s_read_index,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_edge_index,
    output logic [7:0]  m_edge_count,
    output logic        m_edge_valid,
    // pc_limit write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(MAP_ENTRIES);

    logic [15:0]           pc_limit_reg;
    ech_pkg::qctl_t        push;
    logic [AW-1:0]         push_addr;
    logic                  q_full;
    ech_pkg::qctl_t        head;
    logic [AW-1:0]         head_addr;
    logic                  pop;
    ech_pkg::back_status_t status;

    // pc limit register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_limit_reg <= ech_pkg::PC_LIMIT_RESET;
        end else if (cfg_valid) begin
            pc_limit_reg <= cfg_data;
        end
    end

    // classify beats and keep the run state (previous pc, sample count)
    ech_front #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .AW          (AW)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_pc_value   (s_pc_value),
        .s_read_index (s_read_index),
        .pc_limit     (pc_limit_reg),
        .q_full       (q_full),
        .status       (status),
        .push         (push),
        .push_addr    (push_addr)
    );

    // decouples the front end from memory and output stalls
    ech_queue #(
        .AW (AW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_addr (push_addr),
        .full      (q_full),
        .head      (head),
        .head_addr (head_addr),
        .pop       (pop)
    );

    // counter memory, sweep and result register
    ech_back #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .AW          (AW)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .head_addr    (head_addr),
        .pop          (pop),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_edge_index (m_edge_index),
        .m_edge_count (m_edge_count),
        .m_edge_valid (m_edge_valid)
    );

`ifndef SYNTH
    // a result without an edge or read carries an all zero payload
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_edge_valid) |-> (m_edge_index == 16'd0 && m_edge_count == 8'd0))
        else $error("non-edge result with nonzero payload");

    // no input beat is taken while the map is being swept
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        status.sweeping |-> !(s_valid && s_ready))
        else $error("input beat accepted during sweep");

    // the map engine starts out sweeping after reset
    a_sweep_after_reset: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> status.sweeping)
        else $error("no sweep after reset");

    // the map engine only pops a queued beat, and never while sweeping
    a_pop_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (head.valid && !status.sweeping))
        else $error("pop from empty queue or during sweep");
`endif

endmodule
